### sv/tce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

    localparam int NUM_REGS    = 8;
    localparam int WORD_BITS   = 16;
    localparam int DATA_WORDS  = 16;

    localparam int REG_BITS    = $clog2(NUM_REGS);
    localparam int ADDR_BITS   = $clog2(DATA_WORDS);
    localparam int MID_BITS    = 4;
    localparam int OPC_BITS    = 4;
    localparam int INDEX_BITS  = 4;
    localparam int KIND_BITS   = 2;

    // instruction field positions
    localparam int TYPE_POS    = 15;
    localparam int OPC_LSB     = 11;
    localparam int IMM_POS     = 10;
    localparam int DST_LSB     = 7;
    localparam int MID_LSB     = 3;
    localparam int SRC2_LSB    = 0;

    typedef enum logic [OPC_BITS-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_AND   = 4'd2,
        OP_OR    = 4'd3,
        OP_XOR   = 4'd4,
        OP_LOAD  = 4'd5,
        OP_STORE = 4'd6
    } opcode_t;

    typedef enum logic [KIND_BITS-1:0] {
        WK_NONE = 2'd0,
        WK_REG  = 2'd1,
        WK_MEM  = 2'd2
    } write_kind_t;

    typedef struct packed {
        logic                 en;
        logic [REG_BITS-1:0]  addr;
        logic [WORD_BITS-1:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] data;
    } dm_wr_t;

endpackage

`default_nettype wire

### sv/tce_regfile.sv
`timescale 1ns / 1ps
`default_nettype none

module tce_regfile (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tce_pkg::rf_wr_t               wr,
    input  wire logic                          rd_en,
    input  wire logic [tce_pkg::REG_BITS-1:0]  rd_addr_a,
    input  wire logic [tce_pkg::REG_BITS-1:0]  rd_addr_b,
    output logic      [tce_pkg::WORD_BITS-1:0] rd_data_a,
    output logic      [tce_pkg::WORD_BITS-1:0] rd_data_b
);
    import tce_pkg::*;

    logic [WORD_BITS-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]  vld_reg;
    logic [WORD_BITS-1:0] rd_a_reg;
    logic [WORD_BITS-1:0] rd_b_reg;

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read-before-write on a same-cycle clash; caller forwards
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= vld_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
            rd_b_reg <= vld_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

### sv/tce_datamem.sv
`timescale 1ns / 1ps
`default_nettype none

module tce_datamem (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tce_pkg::dm_wr_t               wr,
    input  wire logic                          rd_en,
    input  wire logic [tce_pkg::ADDR_BITS-1:0] rd_addr,
    output logic      [tce_pkg::WORD_BITS-1:0] rd_data
);
    import tce_pkg::*;

    logic [WORD_BITS-1:0]  mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] vld_reg;
    logic [WORD_BITS-1:0]  rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

### sv/toy_cpu_instruction_execute.sv
`timescale 1ns / 1ps
`default_nettype none

// Executes one 16-bit instruction per transaction against an 8 x 16 register
// file and a 16 x 16 data memory, and reports the write it made.
// Input channel: s_valid / s_ready with s_instruction_word.
// Result channel: m_valid / m_ready with m_write_kind (0 none, 1 register,
// 2 data memory), m_write_index and m_write_value; one result per instruction.
// Operands are read from the memories at the accepting edge; the execute stage
// then writes its result into the output register once it may advance.
// Throughput: one instruction per cycle while the receiver does not stall, set
// by the single read/modify/write pass through each memory; a write is
// forwarded to the following instruction.
// Receiver stall: the output register holds its result, the execute stage
// holds behind it and s_ready drops only when both are full; no result is
// lost or repeated. Writes commit when a result enters the output register.
// Reset (aresetn low, synchronous): all registers and data words read as zero
// afterwards, both stages empty. No clearing pass: per-entry valid bits.
module toy_cpu_instruction_execute (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [tce_pkg::WORD_BITS-1:0]  s_instruction_word,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [tce_pkg::KIND_BITS-1:0]  m_write_kind,
    output logic      [tce_pkg::INDEX_BITS-1:0] m_write_index,
    output logic      [tce_pkg::WORD_BITS-1:0]  m_write_value
);
    import tce_pkg::*;

    logic                   accept;
    logic                   s1_adv;
    logic                   s1_vld_reg;
    logic [WORD_BITS-1:0]   s1_instr_reg;

    logic                   m_valid_reg;
    write_kind_t            kind_reg;
    logic [INDEX_BITS-1:0]  index_reg;
    logic [WORD_BITS-1:0]   value_reg;

    write_kind_t            kind_next;
    logic [INDEX_BITS-1:0]  index_next;
    logic [WORD_BITS-1:0]   value_next;

    // read-side decode of the incoming word
    logic                   in_store;
    logic [REG_BITS-1:0]    in_addr_a;
    logic [REG_BITS-1:0]    in_addr_b;
    logic [ADDR_BITS-1:0]   in_daddr;

    // execute-side decode
    logic                   ex_type;
    logic [OPC_BITS-1:0]    ex_opc;
    logic                   ex_imm;
    logic [REG_BITS-1:0]    ex_dst;
    logic [MID_BITS-1:0]    ex_mid;
    logic [REG_BITS-1:0]    ex_src2;
    logic                   ex_store;
    logic [REG_BITS-1:0]    ex_addr_a;

    logic [WORD_BITS-1:0]   rf_a;
    logic [WORD_BITS-1:0]   rf_b;
    logic [WORD_BITS-1:0]   dm_q;
    logic [WORD_BITS-1:0]   reg_a;
    logic [WORD_BITS-1:0]   reg_b;
    logic [WORD_BITS-1:0]   mem_d;
    logic [WORD_BITS-1:0]   op_a;

    rf_wr_t                 rf_wr;
    dm_wr_t                 dm_wr;

    assign s1_adv  = s1_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_vld_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    assign in_store  = s_instruction_word[TYPE_POS] &&
                       (s_instruction_word[OPC_LSB +: OPC_BITS] == OP_STORE);
    assign in_addr_a = in_store ? s_instruction_word[DST_LSB +: REG_BITS]
                                : s_instruction_word[MID_LSB +: REG_BITS];
    assign in_addr_b = s_instruction_word[SRC2_LSB +: REG_BITS];
    assign in_daddr  = s_instruction_word[MID_LSB +: ADDR_BITS];

    tce_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (rf_wr),
        .rd_en     (accept),
        .rd_addr_a (in_addr_a),
        .rd_addr_b (in_addr_b),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    tce_datamem u_datamem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (dm_wr),
        .rd_en   (accept),
        .rd_addr (in_daddr),
        .rd_data (dm_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (accept) begin
            s1_vld_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_instr_reg <= s_instruction_word;
        end
    end

    assign ex_type   = s1_instr_reg[TYPE_POS];
    assign ex_opc    = s1_instr_reg[OPC_LSB +: OPC_BITS];
    assign ex_imm    = s1_instr_reg[IMM_POS];
    assign ex_dst    = s1_instr_reg[DST_LSB +: REG_BITS];
    assign ex_mid    = s1_instr_reg[MID_LSB +: MID_BITS];
    assign ex_src2   = s1_instr_reg[SRC2_LSB +: REG_BITS];
    assign ex_store  = ex_type && (ex_opc == OP_STORE);
    assign ex_addr_a = ex_store ? ex_dst : ex_mid[REG_BITS-1:0];

    // The output register holds the most recent write; any older write was
    // already in the memory when this instruction's operands were read.
    always_comb begin
        reg_a = rf_a;
        reg_b = rf_b;
        mem_d = dm_q;
        if (kind_reg == WK_REG) begin
            if (index_reg == {{(INDEX_BITS-REG_BITS){1'b0}}, ex_addr_a}) begin
                reg_a = value_reg;
            end
            if (index_reg == {{(INDEX_BITS-REG_BITS){1'b0}}, ex_src2}) begin
                reg_b = value_reg;
            end
        end
        if (kind_reg == WK_MEM &&
            index_reg == INDEX_BITS'(ex_mid[ADDR_BITS-1:0])) begin
            mem_d = value_reg;
        end
    end

    assign op_a = ex_imm ? {{(WORD_BITS-MID_BITS){1'b0}}, ex_mid} : reg_a;

    always_comb begin
        kind_next  = WK_REG;
        index_next = {{(INDEX_BITS-REG_BITS){1'b0}}, ex_dst};
        value_next = '0;
        if (!ex_type) begin
            unique case (ex_opc)
                OP_ADD:  value_next = op_a + reg_b;
                OP_SUB:  value_next = op_a - reg_b;
                OP_AND:  value_next = op_a & reg_b;
                OP_OR:   value_next = op_a | reg_b;
                OP_XOR:  value_next = op_a ^ reg_b;
                default: begin
                    kind_next  = WK_NONE;
                    index_next = '0;
                end
            endcase
        end else begin
            unique case (ex_opc)
                OP_LOAD:  value_next = mem_d;
                OP_STORE: begin
                    kind_next  = WK_MEM;
                    index_next = INDEX_BITS'(ex_mid[ADDR_BITS-1:0]);
                    value_next = reg_a;
                end
                default: begin
                    kind_next  = WK_NONE;
                    index_next = '0;
                end
            endcase
        end
    end

    assign rf_wr.en   = s1_adv && (kind_next == WK_REG);
    assign rf_wr.addr = ex_dst;
    assign rf_wr.data = value_next;
    assign dm_wr.en   = s1_adv && (kind_next == WK_MEM);
    assign dm_wr.addr = ex_mid[ADDR_BITS-1:0];
    assign dm_wr.data = value_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            kind_reg    <= WK_NONE;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
            kind_reg    <= kind_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            index_reg <= index_next;
            value_reg <= value_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_write_kind  = kind_reg;
    assign m_write_index = index_reg;
    assign m_write_value = value_reg;

endmodule

`default_nettype wire

### tb/tb_toy_cpu_instruction_execute.sv
`timescale 1ns / 1ps

module tb_toy_cpu_instruction_execute;
    import tce_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 550;   // per idling phase
    localparam int PRINT_LIMIT  = 40;

    // opcodes outside the package enum
    localparam logic [OPC_BITS-1:0] OPC_SPARE = 4'd7;
    localparam logic [OPC_BITS-1:0] OPC_TOP   = 4'd15;

    typedef struct {
        write_kind_t            kind;
        logic [INDEX_BITS-1:0]  index;
        logic [WORD_BITS-1:0]   value;
    } write_rec_t;

    class exec_scoreboard;
        logic [WORD_BITS-1:0] reg_file [NUM_REGS];
        logic [WORD_BITS-1:0] data_words [DATA_WORDS];
        write_rec_t           expected_writes [$];

        function new();
            foreach (reg_file[i]) reg_file[i] = '0;
            foreach (data_words[i]) data_words[i] = '0;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // execute one accepted instruction and queue the write it must report
        function void note_instruction(logic [WORD_BITS-1:0] w);
            logic                 is_xfer;
            logic [OPC_BITS-1:0]  opc;
            logic                 imm;
            logic [REG_BITS-1:0]  dst;
            logic [MID_BITS-1:0]  mid;
            logic [REG_BITS-1:0]  src2;
            logic [WORD_BITS-1:0] a;
            logic [WORD_BITS-1:0] b;
            logic                 alu_ok;
            write_rec_t           rec;
            is_xfer = w[TYPE_POS];
            opc     = w[OPC_LSB +: OPC_BITS];
            imm     = w[IMM_POS];
            dst     = w[DST_LSB +: REG_BITS];
            mid     = w[MID_LSB +: MID_BITS];
            src2    = w[SRC2_LSB +: REG_BITS];
            rec.kind  = WK_NONE;
            rec.index = '0;
            rec.value = '0;
            if (!is_xfer) begin
                // register mode uses only the low bits of the wide field
                a = imm ? WORD_BITS'(mid) : reg_file[mid[REG_BITS-1:0]];
                b = reg_file[src2];
                alu_ok = 1'b1;
                case (opc)
                    OP_ADD: rec.value = a + b;
                    OP_SUB: rec.value = a - b;
                    OP_AND: rec.value = a & b;
                    OP_OR:  rec.value = a | b;
                    OP_XOR: rec.value = a ^ b;
                    default: alu_ok = 1'b0;
                endcase
                if (alu_ok) begin
                    reg_file[dst] = rec.value;
                    rec.kind  = WK_REG;
                    rec.index = INDEX_BITS'(dst);
                end else begin
                    rec.value = '0;
                end
            end else begin
                case (opc)
                    OP_LOAD: begin
                        rec.value = data_words[mid];
                        reg_file[dst] = rec.value;
                        rec.kind  = WK_REG;
                        rec.index = INDEX_BITS'(dst);
                    end
                    OP_STORE: begin
                        rec.value = reg_file[dst];
                        data_words[mid] = rec.value;
                        rec.kind  = WK_MEM;
                        rec.index = INDEX_BITS'(mid);
                    end
                    default: ;
                endcase
            end
            expected_writes.push_back(rec);
        endfunction

        // empty string when the result matches the oldest expectation
        function string check_result(write_kind_t kind, logic [INDEX_BITS-1:0] index,
                                     logic [WORD_BITS-1:0] value);
            write_rec_t exp_rec;
            string      msg;
            if (expected_writes.size() == 0)
                return $sformatf("result kind %0d index %0d value %h with nothing outstanding",
                                 kind, index, value);
            exp_rec = expected_writes.pop_front();
            msg = "";
            if (kind !== exp_rec.kind)
                msg = {msg, $sformatf(" kind %0d exp %0d", kind, exp_rec.kind)};
            if (index !== exp_rec.index)
                msg = {msg, $sformatf(" index %0d exp %0d", index, exp_rec.index)};
            if (value !== exp_rec.value)
                msg = {msg, $sformatf(" value %h exp %h", value, exp_rec.value)};
            return msg;
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [WORD_BITS-1:0]  s_instruction_word;
    logic                  m_valid;
    logic                  m_ready;
    logic [KIND_BITS-1:0]  m_write_kind;
    logic [INDEX_BITS-1:0] m_write_index;
    logic [WORD_BITS-1:0]  m_write_value;

    exec_scoreboard sb;
    int             errors;
    int             cycles;
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             hold_request;

    toy_cpu_instruction_execute dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_instruction_word (s_instruction_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_write_kind       (m_write_kind),
        .m_write_index      (m_write_index),
        .m_write_value      (m_write_value)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report(input string msg);
        if (errors < PRINT_LIMIT)
            $display("mismatch at cycle %0d:%s", cycles, msg);
        errors++;
    endtask

    function automatic logic [WORD_BITS-1:0] enc(input logic is_xfer,
                                                 input logic [OPC_BITS-1:0] opc,
                                                 input logic imm,
                                                 input logic [REG_BITS-1:0] dst,
                                                 input logic [MID_BITS-1:0] mid,
                                                 input logic [REG_BITS-1:0] src2);
        return {is_xfer, opc, imm, dst, mid, src2};
    endfunction

    // mostly well-formed ALU and load/store traffic, some raw words
    function automatic logic [WORD_BITS-1:0] random_instruction();
        int                  pick;
        logic                is_xfer;
        logic [OPC_BITS-1:0] opc;
        pick = $urandom_range(99);
        if (pick < 10)
            return WORD_BITS'($urandom);
        if (pick < 62) begin
            is_xfer = 1'b0;
            opc     = OPC_BITS'($urandom_range(int'(OP_XOR), int'(OP_ADD)));
        end else if (pick < 94) begin
            is_xfer = 1'b1;
            opc     = $urandom_range(1) ? OP_LOAD : OP_STORE;
        end else begin
            is_xfer = 1'($urandom);
            opc     = OPC_BITS'($urandom_range(int'(OPC_TOP), int'(OP_LOAD)));
        end
        return enc(is_xfer, opc, 1'($urandom), REG_BITS'($urandom), MID_BITS'($urandom),
                   REG_BITS'($urandom));
    endfunction

    task automatic send_instruction(input logic [WORD_BITS-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_instruction_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_instruction(w);
    endtask

    // result side: check on each transaction, stall at random, one long hold-off
    initial begin
        int    hold_left;
        bit    held;
        string msg;
        hold_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                msg = sb.check_result(write_kind_t'(m_write_kind), m_write_index,
                                      m_write_value);
                if (msg != "")
                    report(msg);
            end
            if (hold_request && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        logic [WORD_BITS-1:0] directed [$];
        aclk               = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_instruction_word = '0;
        errors             = 0;
        cycles             = 0;
        hold_request       = 1'b0;
        send_idle_pct      = 26;
        recv_idle_pct      = 48;
        sb = new();

        directed = '{
            enc(1'b0, OP_ADD,   1'b0, 3'd0, 4'h0, 3'd0),  // all-zero word
            enc(1'b0, OP_XOR,   1'b1, 3'd1, 4'hF, 3'd0),  // largest immediate
            enc(1'b0, OP_SUB,   1'b1, 3'd2, 4'h0, 3'd1),  // negative difference
            enc(1'b0, OP_ADD,   1'b0, 3'd3, 4'h2, 3'd2),  // carry out of bit 15
            enc(1'b0, OP_ADD,   1'b0, 3'd4, 4'hA, 3'd3),  // top bit of register field
            enc(1'b0, OP_AND,   1'b0, 3'd5, 4'h3, 3'd2),
            enc(1'b0, OP_OR,    1'b1, 3'd6, 4'h9, 3'd1),
            enc(1'b0, OP_XOR,   1'b0, 3'd7, 4'hF, 3'd3),
            enc(1'b1, OP_LOAD,  1'b0, 3'd7, 4'hF, 3'd0),  // word never stored
            enc(1'b1, OP_STORE, 1'b1, 3'd4, 4'h0, 3'd7),
            enc(1'b1, OP_STORE, 1'b0, 3'd3, 4'hF, 3'd5),
            enc(1'b1, OP_LOAD,  1'b0, 3'd0, 4'hF, 3'd0),
            enc(1'b1, OP_LOAD,  1'b1, 3'd1, 4'h0, 3'd3),
            enc(1'b0, OP_LOAD,  1'b0, 3'd1, 4'h0, 3'd0),  // transfer code on ALU side
            enc(1'b0, OPC_SPARE, 1'b0, 3'd2, 4'h5, 3'd6),
            enc(1'b0, OPC_TOP,  1'b1, 3'd7, 4'hF, 3'd7),
            enc(1'b1, OP_ADD,   1'b0, 3'd2, 4'h2, 3'd2),  // ALU code on transfer side
            enc(1'b1, OPC_TOP,  1'b1, 3'd7, 4'hF, 3'd7),  // all-ones word
            enc(1'b1, OPC_SPARE, 1'b0, 3'd5, 4'h8, 3'd1),
            enc(1'b0, OP_SUB,   1'b0, 3'd0, 4'h0, 3'd0),
            enc(1'b0, OP_ADD,   1'b1, 3'd1, 4'hF, 3'd0),
            enc(1'b1, OP_STORE, 1'b0, 3'd1, 4'h8, 3'd0),
            enc(1'b1, OP_LOAD,  1'b0, 3'd6, 4'h8, 3'd0)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_instruction(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_instruction(random_instruction());

        send_idle_pct = 48;
        recv_idle_pct = 26;
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_instruction(random_instruction());

        // no idling; receiver stalls for a long stretch so the pipe backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_instruction(random_instruction());
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
sv/tce_pkg.sv
sv/tce_regfile.sv
sv/tce_datamem.sv
sv/toy_cpu_instruction_execute.sv
tb/tb_toy_cpu_instruction_execute.sv
